// File: design/jsc_pkg.sv
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared widths and codes for the JSON syntax checker.
// ----------------------------------------------------------------------------
package jsc_pkg;

    localparam int MaxNest    = 64;
    localparam int DepthW     = $clog2(MaxNest + 2);
    localparam int StackDepth = MaxNest + 1;
    localparam int StackIdxW  = $clog2(StackDepth);

    typedef enum logic [4:0] {
        ST_OK        = 5'd0,
        ST_DEPTH     = 5'd1,
        ST_EOF       = 5'd2,
        ST_LITERAL   = 5'd3,
        ST_KEY       = 5'd4,
        ST_COLON     = 5'd5,
        ST_OBJ_SEP   = 5'd6,
        ST_ARR_SEP   = 5'd7,
        ST_TRUNC_HEX = 5'd8,
        ST_BAD_HEX   = 5'd9,
        ST_UNTERM    = 5'd10,
        ST_CONTROL   = 5'd11,
        ST_ESC_EOF   = 5'd12,
        ST_BAD_ESC   = 5'd13,
        ST_NUMBER    = 5'd14,
        ST_LEAD_ZERO = 5'd15,
        ST_NO_FRAC   = 5'd16,
        ST_NO_EXP    = 5'd17,
        ST_TRAILING  = 5'd18
    } status_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] text_byte;
        logic       doc_end;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]  status;
        logic [31:0] error_offset;
        logic [31:0] error_line;
    } out_beat_t;

endpackage

// File: design/jsc_if.sv
// ----------------------------------------------------------------------------
// jsc_in_if / jsc_out_if / jsc_cfg_if
// Valid/ready channels of the JSON syntax checker.
// ----------------------------------------------------------------------------
interface jsc_in_if
    import jsc_pkg::*;
();
    logic     valid;
    logic     ready;
    in_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jsc_out_if
    import jsc_pkg::*;
();
    logic      valid;
    logic      ready;
    out_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jsc_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] depth_limit;
    modport source (output valid, output depth_limit, input ready);
    modport sink   (input valid, input depth_limit, output ready);
endinterface

// File: design/json_syntax_checker_unit.sv
// ----------------------------------------------------------------------------
// json_syntax_checker_unit
// Byte-serial JSON syntax checker with nesting stack and first-error capture.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// in_ch    | in  | has_byte, text_byte, doc_end
// out_ch   | out | status, error_offset, error_line
// cfg_ch   | in  | depth_limit
//
// one beat per cycle while ready; the scan state updates on each taken beat
// the result of an end beat is registered and shown the next cycle
// a waiting result holds only an end beat back, while out_ch.ready is low
// reset clears the scan state, depth_limit returns to 64
// ----------------------------------------------------------------------------
module json_syntax_checker_unit
    import jsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    jsc_in_if.sink    in_ch,
    jsc_out_if.source out_ch,
    jsc_cfg_if.sink   cfg_ch
);

    typedef enum logic [4:0] {
        PH_VALUE, PH_ARR_FIRST, PH_OBJ_FIRST, PH_KEY, PH_COLON, PH_AFTER,
        PH_STR, PH_ESC, PH_HEX, PH_HEXBAD, PH_LIT, PH_NSIGN, PH_NZERO,
        PH_NINT, PH_NDOT, PH_NFRAC, PH_NE, PH_NESIGN, PH_NEXP, PH_DONE
    } phase_t;

    logic [6:0]            limit_reg;
    logic [StackDepth-1:0] stack_reg, stack_next;
    logic [DepthW-1:0]     depth_reg, depth_next;
    phase_t                phase_reg, phase_next;
    logic [2:0]            sub_reg, sub_next;
    logic [1:0]            kind_reg, kind_next;
    logic [31:0]           pos_reg, pos_next;
    logic [31:0]           nl_reg, nl_next;
    logic [31:0]           toff_reg, toff_next;
    logic [31:0]           tline_reg, tline_next;
    logic [4:0]            err_reg, err_next;
    logic [31:0]           eoff_reg, eoff_next;
    logic [31:0]           eline_reg, eline_next;
    logic                  ovalid_reg, ovalid_next;
    out_beat_t             obeat_reg, obeat_next;

    logic              take;
    logic              push_en;
    logic              pop_en;
    logic              push_mark;
    logic [7:0]        c;
    logic [31:0]       line_here;
    logic [31:0]       pos_inc;
    logic [DepthW-1:0] eff_limit;
    logic              top_obj;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !ovalid_reg || out_ch.ready || !in_ch.data.doc_end;
    assign take         = in_ch.valid && in_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = obeat_reg;
    assign ovalid_next  = (take && in_ch.data.doc_end) ? 1'b1
                          : (out_ch.ready ? 1'b0 : ovalid_reg);

    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
    endfunction

    function automatic logic is_dig(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
    endfunction

    // expected letter of a literal at a given index
    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            2'd1:
            begin
                case (i)
                    3'd0: r = "f";
                    3'd1: r = "a";
                    3'd2: r = "l";
                    3'd3: r = "s";
                    default: r = "e";
                endcase
            end
            2'd2:
            begin
                case (i)
                    3'd0: r = "n";
                    3'd1: r = "u";
                    3'd2, 3'd3: r = "l";
                    default: r = 8'h00;
                endcase
            end
            default:
            begin
                case (i)
                    3'd0: r = "t";
                    3'd1: r = "r";
                    3'd2: r = "u";
                    3'd3: r = "e";
                    default: r = 8'h00;
                endcase
            end
        endcase
        return r;
    endfunction

    assign c         = in_ch.data.text_byte;
    assign line_here = sat_inc(nl_reg);
    assign pos_inc   = sat_inc(pos_reg);
    assign eff_limit = (limit_reg > 7'(MaxNest)) ? DepthW'(MaxNest) : DepthW'(limit_reg);
    assign top_obj   = (depth_reg != '0) && stack_reg[0];

    // next scan state for one beat
    always_comb
    begin
        logic redo;
        logic [2:0] n;
        logic bad;
        logic [2:0] li;
        logic [1:0] lk;
        logic [31:0] eline;
        depth_next = depth_reg;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        nl_next    = nl_reg;
        toff_next  = toff_reg;
        tline_next = tline_reg;
        err_next   = err_reg;
        eoff_next  = eoff_reg;
        eline_next = eline_reg;
        stack_next = stack_reg;
        push_en    = 1'b0;
        pop_en     = 1'b0;
        push_mark  = 1'b0;
        obeat_next = obeat_reg;
        redo       = 1'b0;
        n          = 3'd0;
        bad        = 1'b0;
        li         = 3'd0;
        lk         = 2'd0;
        eline      = 32'd0;

        if (in_ch.data.has_byte && err_reg == ST_OK)
        begin
            // number phases end by handing the byte to the after-value check
            case (phase_reg)
                PH_NZERO, PH_NINT:
                begin
                    if (is_dig(c))
                    begin
                        if (phase_reg == PH_NZERO)
                        begin
                            err_next = ST_LEAD_ZERO; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                    end
                    else if (c == ".") phase_next = PH_NDOT;
                    else if (c == "e" || c == "E") phase_next = PH_NE;
                    else redo = 1'b1;
                end
                PH_NFRAC:
                begin
                    if (c == "e" || c == "E") phase_next = PH_NE;
                    else if (!is_dig(c)) redo = 1'b1;
                end
                PH_NEXP:
                begin
                    if (!is_dig(c)) redo = 1'b1;
                end
                default: ;
            endcase

            if (redo || phase_reg == PH_AFTER)
            begin
                phase_next = PH_AFTER;
                if (!is_ws(c))
                begin
                    if (depth_reg == '0)
                    begin
                        err_next = ST_TRAILING; eoff_next = pos_reg;
                        eline_next = line_here; phase_next = PH_DONE;
                    end
                    else if (top_obj)
                    begin
                        if (c == ",") phase_next = PH_KEY;
                        else if (c == "}")
                        begin
                            depth_next = depth_reg - DepthW'(1);
                            pop_en = 1'b1;
                        end
                        else
                        begin
                            err_next = ST_OBJ_SEP; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                    end
                    else
                    begin
                        if (c == ",") phase_next = PH_VALUE;
                        else if (c == "]")
                        begin
                            depth_next = depth_reg - DepthW'(1);
                            pop_en = 1'b1;
                        end
                        else
                        begin
                            err_next = ST_ARR_SEP; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_VALUE, PH_ARR_FIRST:
                    begin
                        if (is_ws(c)) ;
                        else if (phase_reg == PH_ARR_FIRST && c == "]")
                        begin
                            depth_next = depth_reg - DepthW'(1);
                            pop_en = 1'b1;
                            phase_next = PH_AFTER;
                        end
                        else if (depth_reg > eff_limit)
                        begin
                            err_next = ST_DEPTH; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                        else if (c == "{" || c == "[")
                        begin
                            push_mark = (c == "{");
                            if (depth_reg <= DepthW'(MaxNest))
                            begin
                                push_en = 1'b1;
                                depth_next = depth_reg + DepthW'(1);
                            end
                            phase_next = (c == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
                        end
                        else if (c == 8'h22)
                        begin
                            sub_next = 3'd0; phase_next = PH_STR;
                        end
                        else if (c == "t" || c == "f" || c == "n")
                        begin
                            kind_next = (c == "t") ? 2'd0 : ((c == "f") ? 2'd1 : 2'd2);
                            sub_next = 3'd1; toff_next = pos_reg;
                            tline_next = line_here; phase_next = PH_LIT;
                        end
                        else if (c == "-") phase_next = PH_NSIGN;
                        else if (c == "0") phase_next = PH_NZERO;
                        else if (is_dig(c)) phase_next = PH_NINT;
                        else
                        begin
                            err_next = ST_NUMBER; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                    end
                    PH_OBJ_FIRST, PH_KEY:
                    begin
                        if (is_ws(c)) ;
                        else if (c == "}" && phase_reg == PH_OBJ_FIRST)
                        begin
                            depth_next = depth_reg - DepthW'(1);
                            pop_en = 1'b1;
                            phase_next = PH_AFTER;
                        end
                        else if (c == 8'h22)
                        begin
                            sub_next = 3'd4; phase_next = PH_STR;
                        end
                        else
                        begin
                            err_next = ST_KEY; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                    end
                    PH_COLON:
                    begin
                        if (is_ws(c)) ;
                        else if (c == ":") phase_next = PH_VALUE;
                        else
                        begin
                            err_next = ST_COLON; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                    end
                    PH_STR:
                    begin
                        if (c == 8'h22) phase_next = sub_reg[2] ? PH_COLON : PH_AFTER;
                        else if (c < 8'h20)
                        begin
                            err_next = ST_CONTROL; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                        else if (c == 8'h5C) phase_next = PH_ESC;
                    end
                    PH_ESC:
                    begin
                        if (c == 8'h22 || c == 8'h5C || c == "/" || c == "b" || c == "f"
                            || c == "n" || c == "r" || c == "t")
                            phase_next = PH_STR;
                        else if (c == "u")
                        begin
                            sub_next = {sub_reg[2], 2'b00};
                            toff_next = pos_inc; tline_next = line_here;
                            phase_next = PH_HEX;
                        end
                        else
                        begin
                            eline = (c == 8'h0A) ? sat_inc(line_here) : line_here;
                            err_next = ST_BAD_ESC; eoff_next = pos_inc;
                            eline_next = eline; phase_next = PH_DONE;
                        end
                    end
                    PH_HEX, PH_HEXBAD:
                    begin
                        bad = (phase_reg == PH_HEXBAD) || !is_hex(c);
                        n = {1'b0, sub_reg[1:0]} + 3'd1;
                        if (n == 3'd4)
                        begin
                            if (bad)
                            begin
                                err_next = ST_BAD_HEX; eoff_next = toff_reg;
                                eline_next = tline_reg; phase_next = PH_DONE;
                            end
                            else
                            begin
                                sub_next = {sub_reg[2], 2'b00}; phase_next = PH_STR;
                            end
                        end
                        else
                        begin
                            sub_next = {sub_reg[2], n[1:0]};
                            if (bad) phase_next = PH_HEXBAD;
                        end
                    end
                    PH_LIT:
                    begin
                        lk = (kind_reg == 2'd3) ? 2'd0 : kind_reg;
                        li = (sub_reg > 3'd4) ? 3'd4 : sub_reg;
                        if (c != lit_char(lk, li))
                        begin
                            err_next = ST_LITERAL; eoff_next = toff_reg;
                            eline_next = tline_reg; phase_next = PH_DONE;
                        end
                        else
                        begin
                            sub_next = li + 3'd1;
                            if (li + 3'd1 >= ((lk == 2'd1) ? 3'd5 : 3'd4))
                                phase_next = PH_AFTER;
                        end
                    end
                    PH_NSIGN:
                    begin
                        if (c == "0") phase_next = PH_NZERO;
                        else if (is_dig(c)) phase_next = PH_NINT;
                        else
                        begin
                            err_next = ST_NUMBER; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                    end
                    PH_NDOT:
                    begin
                        if (is_dig(c)) phase_next = PH_NFRAC;
                        else
                        begin
                            err_next = ST_NO_FRAC; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                    end
                    PH_NE, PH_NESIGN:
                    begin
                        if (phase_reg == PH_NE && (c == "+" || c == "-"))
                            phase_next = PH_NESIGN;
                        else if (is_dig(c)) phase_next = PH_NEXP;
                        else
                        begin
                            err_next = ST_NO_EXP; eoff_next = pos_reg;
                            eline_next = line_here; phase_next = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
        end

        // byte counters
        if (in_ch.data.has_byte)
        begin
            pos_next = pos_inc;
            if (c == 8'h0A) nl_next = sat_inc(nl_reg);
        end

        // container stack as a shift register, newest mark at bit 0
        if (push_en)
            stack_next = {stack_reg[StackDepth-2:0], push_mark};
        else if (pop_en)
            stack_next = {1'b0, stack_reg[StackDepth-1:1]};

        // end of document: finish check on the updated state
        if (in_ch.data.doc_end)
        begin
            if (err_next == ST_OK)
            begin
                eoff_next = pos_next;
                eline_next = sat_inc(nl_next);
                case (phase_next)
                    PH_VALUE, PH_ARR_FIRST:
                        err_next = (depth_next > eff_limit) ? ST_DEPTH : ST_EOF;
                    PH_OBJ_FIRST, PH_KEY: err_next = ST_KEY;
                    PH_COLON:  err_next = ST_COLON;
                    PH_STR:    err_next = ST_UNTERM;
                    PH_ESC:    err_next = ST_ESC_EOF;
                    PH_HEX, PH_HEXBAD:
                    begin
                        err_next = ST_TRUNC_HEX; eoff_next = toff_next;
                        eline_next = tline_next;
                    end
                    PH_LIT:
                    begin
                        err_next = ST_LITERAL; eoff_next = toff_next;
                        eline_next = tline_next;
                    end
                    PH_NSIGN:  err_next = ST_NUMBER;
                    PH_NDOT:   err_next = ST_NO_FRAC;
                    PH_NE, PH_NESIGN: err_next = ST_NO_EXP;
                    PH_AFTER, PH_NZERO, PH_NINT, PH_NFRAC, PH_NEXP:
                    begin
                        if (depth_next != '0)
                            err_next = stack_next[0] ? ST_OBJ_SEP : ST_ARR_SEP;
                    end
                    default: ;
                endcase
            end
            obeat_next.status       = err_next;
            obeat_next.error_offset = (err_next != ST_OK) ? eoff_next : 32'd0;
            obeat_next.error_line   = (err_next != ST_OK) ? eline_next : 32'd0;
            stack_next = '0;
            depth_next = '0;
            phase_next = PH_VALUE;
            sub_next   = 3'd0;
            kind_next  = 2'd0;
            pos_next   = 32'd0;
            nl_next    = 32'd0;
            toff_next  = 32'd0;
            tline_next = 32'd1;
            err_next   = ST_OK;
            eoff_next  = 32'd0;
            eline_next = 32'd0;
        end
    end

    // scan state, config and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= 7'(MaxNest);
            stack_reg  <= '0;
            depth_reg  <= '0;
            phase_reg  <= PH_VALUE;
            sub_reg    <= 3'd0;
            kind_reg   <= 2'd0;
            pos_reg    <= 32'd0;
            nl_reg     <= 32'd0;
            toff_reg   <= 32'd0;
            tline_reg  <= 32'd1;
            err_reg    <= 5'd0;
            eoff_reg   <= 32'd0;
            eline_reg  <= 32'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
                limit_reg <= cfg_ch.depth_limit;
            ovalid_reg <= ovalid_next;
            if (take)
            begin
                stack_reg <= stack_next;
                depth_reg <= depth_next;
                phase_reg <= phase_next;
                sub_reg   <= sub_next;
                kind_reg  <= kind_next;
                pos_reg   <= pos_next;
                nl_reg    <= nl_next;
                toff_reg  <= toff_next;
                tline_reg <= tline_next;
                err_reg   <= err_next;
                eoff_reg  <= eoff_next;
                eline_reg <= eline_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && in_ch.data.doc_end)
            obeat_reg <= obeat_next;
    end

endmodule
